>>> src/matrix4_transform_accumulator_assert.svh
// Assertion macros for the block's control module.
// Each expects clk and rst_n in scope.
`ifndef MATRIX4_TRANSFORM_ACCUMULATOR_ASSERT_SVH
`define MATRIX4_TRANSFORM_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define MTX4TA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtx4ta: same-cycle check failed");

// next-cycle implication
`define MTX4TA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtx4ta: next-cycle check failed");

`endif

>>> src/mtx4ta_pkg.sv
package mtx4ta_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ACC_W     = 66;  // sum of four 64-bit products, exact

    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [1:0] {
        CMD_IDENT  = 2'd0,
        CMD_WR_CUR = 2'd1,
        CMD_WR_OP  = 2'd2,
        CMD_MUL    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        logic mul_en;   // register a*b
        logic acc_clr;  // start a new sum
        logic acc_en;   // add registered product
    } mac_ctl_t;

    typedef struct packed {
        mac_ctl_t   mac;
        logic       emit;   // result ready, load output
        logic       last;   // sixteenth element
        logic       idle;
        logic [3:0] elem;   // element being formed, col*4+row
        logic [1:0] k;      // term of the dot product
    } seq_ctl_t;

endpackage

>>> src/mtx4ta_mac.sv
module mtx4ta_mac
    import mtx4ta_pkg::*;
(
    input  logic               clk,
    input  mac_ctl_t           ctl,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] res
);

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] shifted;
    logic                    fits;

    always_comb
    begin
        if (ctl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctl.acc_en)
        begin
            acc_next = acc_reg + {{(ACC_W - 64){prod_reg[63]}}, prod_reg};
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= a * b;
        end
        acc_reg <= acc_next;
    end

    // floor shift, then clamp to 32 bits
    assign shifted = acc_reg >>> FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:31]) || !(|shifted[ACC_W-1:31]);

    always_comb
    begin
        if (fits)
        begin
            res = shifted[31:0];
        end
        else if (shifted[ACC_W-1])
        begin
            res = 32'sh8000_0000;
        end
        else
        begin
            res = 32'sh7FFF_FFFF;
        end
    end

endmodule

>>> src/mtx4ta_ctrl.sv
module mtx4ta_ctrl
    import mtx4ta_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,     // multiply item accepted
    input  logic     out_free,  // output register can take a result
    output seq_ctl_t ctl
);

`include "matrix4_transform_accumulator_assert.svh"

    seq_state_t state_reg, state_next;
    logic [3:0] elem_reg, elem_next;
    logic [1:0] k_reg, k_next;
    logic       mul_done;
    logic       out_stall;
    logic       first_term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            elem_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        k_next     = k_reg;
        ctl        = '0;
        ctl.elem   = elem_reg;
        ctl.k      = k_reg;
        ctl.idle   = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MUL;
                    elem_next  = '0;
                    k_next     = '0;
                end
            end
            ST_MUL:
            begin
                ctl.mac.mul_en = 1'b1;
                // first term clears the sum, later terms add the previous product
                if (k_reg == 2'd0)
                begin
                    ctl.mac.acc_clr = 1'b1;
                end
                else
                begin
                    ctl.mac.acc_en = 1'b1;
                end
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                ctl.mac.acc_en = 1'b1;
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    ctl.emit = 1'b1;
                    ctl.last = (elem_reg == 4'd15);
                    if (elem_reg == 4'd15)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        elem_next  = elem_reg + 4'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mul_done   = (state_reg == ST_MUL) && (k_reg == 2'd3);
    assign out_stall  = (state_reg == ST_OUT) && !out_free;
    assign first_term = (state_reg == ST_MUL) && (k_reg == 2'd0) && (elem_reg == 4'd0);

    `MTX4TA_ASSERT_NEXT(a_mul_to_acc, mul_done, (state_reg == ST_ACC))
    `MTX4TA_ASSERT_NEXT(a_last_to_idle, (ctl.emit && ctl.last), (state_reg == ST_IDLE))
    `MTX4TA_ASSERT_NEXT(a_start, (start && state_reg == ST_IDLE), first_term)
    `MTX4TA_ASSERT_NEXT(a_stall_hold, out_stall, (state_reg == ST_OUT && $stable(elem_reg)))

endmodule

>>> src/matrix4_transform_accumulator.sv
// 4x4 Q16.16 transform accumulator. Holds a column-major current matrix
// (identity after reset) and an operand matrix (undefined until written).
// Input items carry a command in s_tuser: load identity, write a current
// element, write an operand element, or multiply in place
// (current = current x operand). Identity loads and element writes produce
// nothing. A multiply produces 16 output items in index order, out_last set
// on the sixteenth; element c*4+r is the floor-shifted, saturated sum over k
// of cur[k*4+r]*op[c*4+k] of the old current matrix. All 64 products go
// through one 32x32 multiplier and one 66-bit accumulator: each element
// passes through one multiply step per term, a final accumulate and an output
// step, and a multiply keeps s_tready low until its last element is emitted,
// including any time the output side stalls. The output register lets a
// finished element wait while the next one is being summed.
module matrix4_transform_accumulator
    import mtx4ta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] elem_index, [35:4] elem_value, [39:36] zero
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] out_index, [35:4] out_value, [39:36] zero
    output logic        m_tlast    // out_last
);

    logic               s_acc;
    cmd_t               cmd;
    logic [3:0]         elem_index;
    logic signed [31:0] elem_value;

    logic signed [31:0] cur_reg [16];
    logic signed [31:0] op_reg  [16];   // no reset: undefined until written
    logic signed [31:0] new_reg [16];   // product elements of the running multiply

    seq_ctl_t           ctl;
    logic               out_free;
    logic signed [31:0] mac_a;
    logic signed [31:0] mac_b;
    logic signed [31:0] mac_res;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [3:0]         out_index_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;

    assign s_acc      = s_tvalid && s_tready;
    assign cmd        = cmd_t'(s_tuser);
    assign elem_index = s_tdata[3:0];
    assign elem_value = s_tdata[35:4];
    assign s_tready   = ctl.idle;
    assign out_free   = !m_tvalid_reg || m_tready;

    mtx4ta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_acc && cmd == CMD_MUL),
        .out_free (out_free),
        .ctl      (ctl)
    );

    // row of the old current matrix, column of the operand
    assign mac_a = cur_reg[{ctl.k, ctl.elem[1:0]}];
    assign mac_b = op_reg[{ctl.elem[3:2], ctl.k}];

    mtx4ta_mac u_mac (
        .clk (clk),
        .ctl (ctl.mac),
        .a   (mac_a),
        .b   (mac_b),
        .res (mac_res)
    );

    // Current matrix: the product replaces it only once all 16 elements exist.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                cur_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
            end
        end
        else if (ctl.emit && ctl.last)
        begin
            for (int i = 0; i < 15; i++)
            begin
                cur_reg[i] <= new_reg[i];
            end
            cur_reg[15] <= mac_res;
        end
        else if (s_acc)
        begin
            case (cmd)
                CMD_IDENT:
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        cur_reg[i] <= (i % 5 == 0) ? ONE_Q : 32'sd0;
                    end
                end
                CMD_WR_CUR:
                begin
                    cur_reg[elem_index] <= elem_value;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && cmd == CMD_WR_OP)
        begin
            op_reg[elem_index] <= elem_value;
        end
        if (ctl.emit)
        begin
            new_reg[ctl.elem] <= mac_res;
        end
    end

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (ctl.emit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_index_reg <= ctl.elem;
            out_value_reg <= mac_res;
            out_last_reg  <= ctl.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> tb/matrix4_product_checker.sv
// Passive checker: mirrors the current/operand matrices from the accepted
// command items, predicts every product element and compares it with what
// leaves the master side.
module matrix4_product_checker
    import mtx4ta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [3:0] elem_index, [35:4] elem_value
    input  logic [1:0]  s_tuser,   // [1:0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [3:0] out_index, [35:4] out_value
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          products_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] value;
        logic        last;
    } product_elem_t;

    localparam logic signed [65:0] SAT_HI = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] SAT_LO = -SAT_HI - 66'sd1;

    logic signed [31:0] cur_m [16];
    logic signed [31:0] op_m  [16];
    product_elem_t      expected_products [$];

    task automatic load_identity();
        for (int i = 0; i < 16; i++)
            cur_m[i] = (i % 5 == 0) ? ONE_Q : 32'sd0;
    endtask

    // current = current x operand; all terms come from the old current matrix
    task automatic multiply_in_place();
        logic signed [31:0] prev [16];
        logic signed [63:0] term;
        logic signed [65:0] acc;
        product_elem_t      p;
        prev = cur_m;
        for (int i = 0; i < 16; i++)
        begin
            acc = '0;
            for (int k = 0; k < 4; k++)
            begin
                term = prev[k * 4 + i % 4] * op_m[(i / 4) * 4 + k];
                acc  = acc + term;
            end
            acc = acc >>> FRAC_BITS;   // floor
            if (acc > SAT_HI)
                p.value = SAT_HI[31:0];
            else if (acc < SAT_LO)
                p.value = SAT_LO[31:0];
            else
                p.value = acc[31:0];
            p.index  = 4'(i);
            p.last   = (i == 15);
            cur_m[i] = p.value;
            expected_products.push_back(p);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_elem_t got;
        product_elem_t want;
        if (!rst_n)
        begin
            load_identity();
            for (int i = 0; i < 16; i++)
                op_m[i] = '0;
            expected_products.delete();
            mismatch_count   = 0;
            products_pending = 0;
        end
        else
        begin
            // output side first: nothing accepted on this edge can match it
            if (m_tvalid && m_tready)
            begin
                got.index = m_tdata[3:0];
                got.value = m_tdata[35:4];
                got.last  = m_tlast;
                if (expected_products.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: product item expected none, got index %0d value %h last %b",
                             $time, got.index, got.value, got.last);
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (got.index !== want.index)
                            $display("%0t: out_index expected %0d got %0d",
                                     $time, want.index, got.index);
                        if (got.value !== want.value)
                            $display("%0t: out_value[%0d] expected %h got %h",
                                     $time, want.index, want.value, got.value);
                        if (got.last !== want.last)
                            $display("%0t: out_last[%0d] expected %b got %b",
                                     $time, want.index, want.last, got.last);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                case (cmd_t'(s_tuser))
                    CMD_IDENT:  load_identity();
                    CMD_WR_CUR: cur_m[s_tdata[3:0]] = s_tdata[35:4];
                    CMD_WR_OP:  op_m[s_tdata[3:0]]  = s_tdata[35:4];
                    default:    multiply_in_place();
                endcase
            end
            products_pending = expected_products.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the 4x4 transform accumulator. Checking lives in
// matrix4_product_checker, which sits beside the block on the same wires.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mtx4ta_pkg::*;

    localparam int N_RANDOM     = 458;   // plus 23 directed items
    localparam int LONG_HOLD    = 400;   // receiver back-pressure stretch
    localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving
    localparam int DRAIN_CYCLES = 20;

    // corner values for the first operand entries
    localparam logic [31:0] EDGE_VALS [8] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001, 32'h8000_0001
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [3:0] elem_index, [35:4] elem_value, [39:36] zero
    logic [1:0]  s_tuser  = '0;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // [3:0] out_index, [35:4] out_value, [39:36] zero
    logic        m_tlast;

    int mismatch_count;
    int products_pending;
    int items_sent = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    matrix4_transform_accumulator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    matrix4_product_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .mismatch_count   (mismatch_count),
        .products_pending (products_pending)
    );

    // Mostly back-to-back, some short gaps, the odd long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Element values: mostly small Q16.16 numbers (about +-4.0) so products
    // stay in range, plus full-range patterns and the saturation corners.
    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1, 2:    v = $urandom();
            3:       v = $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            default: v = 32'($urandom_range(0, 32'h7_FFFF)) - 32'h4_0000;
        endcase
        return v;
    endfunction

    // Drives one command item at the falling edge and holds it until the
    // block takes it. Every fourth run of 25 items goes without gaps.
    task automatic send_item(input cmd_t cmd, input logic [3:0] idx, input logic [31:0] val);
        int n;
        n = ((items_sent % 100) >= 75) ? 0 : idle_gap();
        repeat (n)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, val, idx};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Reset once, released on a falling edge.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog: a stretch with no item moving on either side means a hang.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random ready pattern, with two long hold-offs while the
    // sender keeps offering, so the block backs up into its input.
    initial
    begin : receiver
        int n;
        int holds_done;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (holds_done < 2 && items_sent >= (holds_done == 0 ? 17 : 300))
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            else
            begin
                n = idle_gap();
                repeat (n)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
                repeat (n)
                begin
                    @(negedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Sender: directed corners, then random commands, then the verdict.
    initial
    begin : sender
        int   pick;
        cmd_t cmd;
        wait (rst_n === 1'b1);

        // Fill the whole operand matrix first: reading an operand entry that
        // was never written is not allowed, and nothing is written after
        // this without every entry already being defined.
        for (int i = 0; i < 16; i++)
            send_item(CMD_WR_OP, 4'(i), (i < 8) ? EDGE_VALS[i] : $urandom());

        // identity x operand: product equals the operand exactly
        send_item(CMD_MUL, 4'($urandom_range(0, 15)), $urandom());

        // push the extremes into the current matrix so both saturation
        // limits and the floor of a tiny negative sum show up
        send_item(CMD_WR_CUR, 4'd0,  32'h7FFF_FFFF);
        send_item(CMD_WR_CUR, 4'd15, 32'h8000_0000);
        send_item(CMD_WR_CUR, 4'd5,  32'h0000_0001);
        send_item(CMD_MUL, 4'($urandom_range(0, 15)), $urandom());

        // identity load ignores its index/value; operand must survive it
        send_item(CMD_IDENT, 4'($urandom_range(0, 15)), $urandom());
        send_item(CMD_MUL, 4'($urandom_range(0, 15)), $urandom());

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                // halfway: stop offering and let every product drain out
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (products_pending != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 5)
                cmd = CMD_IDENT;
            else if (pick < 45)
                cmd = CMD_WR_CUR;
            else if (pick < 85)
                cmd = CMD_WR_OP;
            else
                cmd = CMD_MUL;
            send_item(cmd, 4'($urandom_range(0, 15)), random_value());
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        // a product still owed at the end hangs here and the watchdog fails it
        while (products_pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && products_pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
